// ----- rtl/mbe_pkg.sv -----
// shared types and constants for the mandelbrot escape-time block
`timescale 1ns / 1ps
package mbe_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC      = 28;
  localparam int OUT_FRAC  = 24;
  localparam int CNT_W     = 16;
  localparam int IDX_W     = 10;
  localparam int PIX_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int MAG_OUT_W = 32;

  // z fits one bit over the coordinate width while the orbit is bounded
  localparam int Z_W      = COORD_W + 1;
  localparam int PROD_W   = 2 * COORD_W;
  localparam int SQ_W     = PROD_W - FRAC;
  localparam int SUM_W    = SQ_W + 1;
  localparam int M_W      = PROD_W - FRAC + 1;
  localparam int EXT_W    = SUM_W + 1;
  localparam int DIV_CNT_W = $clog2(COORD_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_MIN_REAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_MIN_IMAG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_MAX_REAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_MAX_IMAG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT    = 3'd6;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t cr;
    coord_t ci;
  } point_t;

  typedef struct packed {
    logic               neg_re;
    logic [COORD_W-1:0] mag_re;
    logic               neg_im;
    logic [COORD_W-1:0] mag_im;
  } step_t;

endpackage

// ----- rtl/mbe_if.sv -----
// request and result channel interfaces
`timescale 1ns / 1ps
interface mbe_in_if;
  import mbe_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] column;
  logic [IDX_W-1:0] row;
  modport source (output valid, output column, output row, input ready);
  modport sink (input valid, input column, input row, output ready);
endinterface

interface mbe_out_if;
  import mbe_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CNT_W-1:0]     escape_count;
  logic [MAG_OUT_W-1:0] final_magnitude;
  modport source (output valid, output escape_count, output final_magnitude, input ready);
  modport sink (input valid, input escape_count, input final_magnitude, output ready);
endinterface

// ----- rtl/mbe_step_div.sv -----
// pixel step divider, one quotient bit per cycle for both axes
`timescale 1ns / 1ps
module mbe_step_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  mbe_pkg::coord_t             min_re_i,
  input  mbe_pkg::coord_t             max_re_i,
  input  mbe_pkg::coord_t             min_im_i,
  input  mbe_pkg::coord_t             max_im_i,
  input  logic [mbe_pkg::PIX_W-1:0]   columns_i,
  input  logic [mbe_pkg::PIX_W-1:0]   rows_i,
  output mbe_pkg::step_t              step_o,
  output logic                        busy_o
);
  import mbe_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic [COORD_W-1:0]   qd_re_r, qd_im_r;
  logic [PIX_W-1:0]     rem_re_r, rem_im_r;
  logic [PIX_W-1:0]     dv_re_r, dv_im_r;
  logic                 neg_re_r, neg_im_r;

  logic [COORD_W:0]     diff_re, diff_im;
  logic [COORD_W-1:0]   span_re, span_im;
  logic [PIX_W-1:0]     div_re, div_im;
  logic [PIX_W-1:0]     rem_re_nxt, rem_im_nxt;
  logic [COORD_W-1:0]   qd_re_nxt, qd_im_nxt;

  function automatic logic [PIX_W+COORD_W-1:0] div_bit(
    input logic [PIX_W-1:0]   rem,
    input logic [COORD_W-1:0] qd,
    input logic [PIX_W-1:0]   dv
  );
    logic [PIX_W:0] trial;
    logic [PIX_W:0] left;
    trial = {rem, qd[COORD_W-1]};
    left  = trial - {1'b0, dv};
    if (trial >= {1'b0, dv}) begin
      div_bit = {left[PIX_W-1:0], qd[COORD_W-2:0], 1'b1};
    end else begin
      div_bit = {trial[PIX_W-1:0], qd[COORD_W-2:0], 1'b0};
    end
  endfunction

  assign diff_re = {max_re_i[COORD_W-1], max_re_i} - {min_re_i[COORD_W-1], min_re_i};
  assign diff_im = {max_im_i[COORD_W-1], max_im_i} - {min_im_i[COORD_W-1], min_im_i};
  assign span_re = diff_re[COORD_W] ? COORD_W'(-diff_re) : diff_re[COORD_W-1:0];
  assign span_im = diff_im[COORD_W] ? COORD_W'(-diff_im) : diff_im[COORD_W-1:0];
  assign div_re  = (columns_i < PIX_W'(2)) ? PIX_W'(1) : columns_i - PIX_W'(1);
  assign div_im  = (rows_i < PIX_W'(2)) ? PIX_W'(1) : rows_i - PIX_W'(1);

  assign {rem_re_nxt, qd_re_nxt} = div_bit(rem_re_r, qd_re_r, dv_re_r);
  assign {rem_im_nxt, qd_im_nxt} = div_bit(rem_im_r, qd_im_r, dv_im_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start_i) begin
      cnt_r <= DIV_CNT_W'(COORD_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      qd_re_r  <= span_re;
      qd_im_r  <= span_im;
      rem_re_r <= '0;
      rem_im_r <= '0;
      dv_re_r  <= div_re;
      dv_im_r  <= div_im;
      neg_re_r <= diff_re[COORD_W];
      neg_im_r <= diff_im[COORD_W];
    end else if (cnt_r != '0) begin
      qd_re_r  <= qd_re_nxt;
      qd_im_r  <= qd_im_nxt;
      rem_re_r <= rem_re_nxt;
      rem_im_r <= rem_im_nxt;
    end
  end

  assign busy_o        = (cnt_r != '0);
  assign step_o.neg_re = neg_re_r;
  assign step_o.mag_re = qd_re_r;
  assign step_o.neg_im = neg_im_r;
  assign step_o.mag_im = qd_im_r;

endmodule

// ----- rtl/mbe_front.sv -----
// front end: takes a pixel request and maps it onto the view
`timescale 1ns / 1ps
module mbe_front (
  input  logic            clk,
  input  logic            rst_n,
  mbe_in_if.sink          in_req,
  input  logic            hold_i,
  input  mbe_pkg::coord_t min_re_i,
  input  mbe_pkg::coord_t min_im_i,
  input  mbe_pkg::step_t  step_i,
  output logic            push_o,
  output mbe_pkg::point_t push_data_o,
  input  logic            full_i
);
  import mbe_pkg::*;

  localparam int P_W = COORD_W + IDX_W;
  localparam int T_W = P_W + 2;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_ADD  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] col_r, row_r;
  logic [P_W-1:0]   p_re_r, p_im_r;

  function automatic coord_t place(input coord_t base, input logic neg,
                                   input logic [P_W-1:0] p);
    logic signed [T_W-1:0] t;
    t = neg ? T_W'(base) - $signed({2'b00, p}) : T_W'(base) + $signed({2'b00, p});
    if (!t[T_W-1] && (|t[T_W-2:COORD_W-1])) begin
      place = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (t[T_W-1] && !(&t[T_W-2:COORD_W-1])) begin
      place = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      place = t[COORD_W-1:0];
    end
  endfunction

  assign in_req.ready = (state_r == F_IDLE) && !hold_i;
  assign push_o       = (state_r == F_ADD) && !full_i;
  assign push_data_o.cr = place(min_re_i, step_i.neg_re, p_re_r);
  assign push_data_o.ci = place(min_im_i, step_i.neg_im, p_im_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_req.valid && in_req.ready) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_ADD;
      F_ADD:  if (!full_i) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      col_r <= in_req.column;
      row_r <= in_req.row;
    end
    if (state_r == F_MUL) begin
      p_re_r <= P_W'(step_i.mag_re) * P_W'(col_r);
      p_im_r <= P_W'(step_i.mag_im) * P_W'(row_r);
    end
  end

endmodule

// ----- rtl/mbe_fifo.sv -----
// point queue between the front end and the iteration engine
`timescale 1ns / 1ps
module mbe_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  mbe_pkg::point_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output mbe_pkg::point_t pop_data_o,
  output logic            empty_o
);
  import mbe_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  point_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_r, rd_r;
  logic [CNT_W_Q-1:0] cnt_r;

  assign full_o     = (cnt_r == CNT_W_Q'(DEPTH));
  assign empty_o    = (cnt_r == '0);
  assign pop_data_o = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      if (pop_i)  rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      if (push_i && !pop_i) cnt_r <= cnt_r + CNT_W_Q'(1);
      else if (pop_i && !push_i) cnt_r <= cnt_r - CNT_W_Q'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_r] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W_Q'(DEPTH)) else $error("queue count out of range");

endmodule

// ----- rtl/mbe_iter.sv -----
// iteration engine: z = z*z + c until escape or limit
`timescale 1ns / 1ps
module mbe_iter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      empty_i,
  input  mbe_pkg::point_t           pop_data_i,
  output logic                      pop_o,
  input  logic [mbe_pkg::CNT_W-1:0] limit_i,
  mbe_out_if.source                 out_res
);
  import mbe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]              state_r, state_nxt;
  coord_t                  cr_r, ci_r;
  logic signed [Z_W-1:0]   zr_r, zi_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [PROD_W-1:0]       p_rr_r, p_ii_r, p_ri_r;
  logic                    mneg_r;
  logic [CNT_W-1:0]        res_cnt_r, out_cnt_r;
  logic [MAG_OUT_W-1:0]    res_mag_r, out_mag_r;
  logic                    out_valid_r;

  logic [COORD_W-1:0]      a_re, a_im;
  logic [Z_W-1:0]          neg_re, neg_im;
  logic [SQ_W-1:0]         sr, si;
  logic [SUM_W-1:0]        sum;
  logic [M_W-1:0]          m;
  logic                    finish;
  logic signed [EXT_W-1:0] zr_ext, zi_ext, m_ext;
  logic [SUM_W-FRAC+OUT_FRAC-1:0] mag_sh;
  logic [MAG_OUT_W-1:0]    mag_sat;
  logic                    out_free;

  assign neg_re = -zr_r;
  assign neg_im = -zi_r;
  assign a_re   = zr_r[Z_W-1] ? neg_re[COORD_W-1:0] : zr_r[COORD_W-1:0];
  assign a_im   = zi_r[Z_W-1] ? neg_im[COORD_W-1:0] : zi_r[COORD_W-1:0];

  assign sr  = p_rr_r[PROD_W-1:FRAC];
  assign si  = p_ii_r[PROD_W-1:FRAC];
  assign sum = {1'b0, sr} + {1'b0, si};
  assign m   = p_ri_r[PROD_W-1:FRAC-1];
  assign finish = (sum > (SUM_W'(4) << FRAC)) || (cnt_r >= limit_i);

  assign m_ext  = $signed({1'b0, m});
  assign zr_ext = $signed({2'b00, sr}) - $signed({2'b00, si}) + EXT_W'(cr_r);
  assign zi_ext = (mneg_r ? -m_ext : m_ext) + EXT_W'(ci_r);

  assign mag_sh  = sum[SUM_W-1:FRAC-OUT_FRAC];
  assign mag_sat = (|mag_sh[$bits(mag_sh)-1:MAG_OUT_W]) ? '1 : mag_sh[MAG_OUT_W-1:0];

  assign out_free = !out_valid_r || out_res.ready;
  assign pop_o    = (state_r == ST_IDLE) && !empty_i;

  assign out_res.valid           = out_valid_r;
  assign out_res.escape_count    = out_cnt_r;
  assign out_res.final_magnitude = out_mag_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!empty_i) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = finish ? ST_DONE : ST_MUL;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop_o) begin
        cnt_r <= '0;
      end else if (state_r == ST_EVAL && !finish) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      cr_r <= pop_data_i.cr;
      ci_r <= pop_data_i.ci;
      zr_r <= '0;
      zi_r <= '0;
    end
    if (state_r == ST_MUL) begin
      p_rr_r <= PROD_W'(a_re) * PROD_W'(a_re);
      p_ii_r <= PROD_W'(a_im) * PROD_W'(a_im);
      p_ri_r <= PROD_W'(a_re) * PROD_W'(a_im);
      mneg_r <= zr_r[Z_W-1] ^ zi_r[Z_W-1];
    end
    if (state_r == ST_EVAL) begin
      if (finish) begin
        res_cnt_r <= cnt_r;
        res_mag_r <= mag_sat;
      end else begin
        zr_r <= zr_ext[Z_W-1:0];
        zi_r <= zi_ext[Z_W-1:0];
      end
    end
    if (state_r == ST_DONE && out_free) begin
      out_cnt_r <= res_cnt_r;
      out_mag_r <= res_mag_r;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (cnt_r <= limit_i)) else $error("count passed limit");
  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cnt_r <= limit_i)) else $error("result count passed limit");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |=> (state_r == ST_MUL && cnt_r == '0)) else $error("bad point load");
  a_done_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> out_valid_r) else $error("result dropped");

endmodule

// ----- rtl/mandelbrot_escape_time.sv -----
// top level of the mandelbrot escape-time point evaluator
`timescale 1ns / 1ps
// Each request names a pixel by column and row; the block maps it onto the
// configured view and returns the iteration count and the final |z|^2 in
// Q8.24. Each iteration passes through a multiply state, in the three
// 32x32 multipliers, and an evaluate state that tests and updates z; the
// coordinate mapping (a multiply state, then an add state) runs ahead
// through a small queue. After reset and after every register write the
// pixel steps are divided out one bit per cycle, and no request is taken
// while the division runs.
module mandelbrot_escape_time #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mbe_in_if.sink                          in_req,
  mbe_out_if.source                       out_res,
  input  logic                            cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbe_pkg::COORD_W-1:0]     cfg_data
);
  import mbe_pkg::*;

  coord_t           min_re_r, min_im_r, max_re_r, max_im_r;
  logic [PIX_W-1:0] columns_r, rows_r;
  logic [CNT_W-1:0] limit_r;
  logic             start_r, start_nxt;

  step_t            step;
  logic             div_busy;
  logic             push, pop, full, empty;
  point_t           push_data, pop_data;

  assign start_nxt = cfg_we && (cfg_index <= REG_ITER_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_re_r  <= -(COORD_W'(1) << (FRAC + 1));
      min_im_r  <= -(COORD_W'(1) << FRAC);
      max_re_r  <= COORD_W'(1) << FRAC;
      max_im_r  <= COORD_W'(1) << FRAC;
      columns_r <= PIX_W'(80);
      rows_r    <= PIX_W'(24);
      limit_r   <= CNT_W'(255);
      start_r   <= 1'b1;
    end else begin
      start_r <= start_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_VIEW_MIN_REAL: min_re_r  <= cfg_data;
          REG_VIEW_MIN_IMAG: min_im_r  <= cfg_data;
          REG_VIEW_MAX_REAL: max_re_r  <= cfg_data;
          REG_VIEW_MAX_IMAG: max_im_r  <= cfg_data;
          REG_COLUMNS:       columns_r <= cfg_data[PIX_W-1:0];
          REG_ROWS:          rows_r    <= cfg_data[PIX_W-1:0];
          REG_ITER_LIMIT:    limit_r   <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  mbe_step_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (start_r),
    .min_re_i  (min_re_r),
    .max_re_i  (max_re_r),
    .min_im_i  (min_im_r),
    .max_im_i  (max_im_r),
    .columns_i (columns_r),
    .rows_i    (rows_r),
    .step_o    (step),
    .busy_o    (div_busy)
  );

  mbe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .hold_i      (div_busy || start_r || start_nxt),
    .min_re_i    (min_re_r),
    .min_im_i    (min_im_r),
    .step_i      (step),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  mbe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  mbe_iter u_iter (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .limit_i    (limit_r),
    .out_res    (out_res)
  );

endmodule
